FILE: src/slip_pkg.sv
// shared constants and types for the slip byte decoder
package slip_pkg;

    // framing symbols
    localparam logic [7:0] SYM_END     = 8'o300;
    localparam logic [7:0] SYM_ESC     = 8'o333;
    localparam logic [7:0] SYM_ESC_END = 8'o334;
    localparam logic [7:0] SYM_ESC_ESC = 8'o335;

    // frame buffer depth and the largest limit a 9-bit count can reach
    localparam int BUF_DEPTH = 256;
    localparam int COUNT_W   = 9;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int LIMIT_CAP = (BUF_DEPTH > COUNT_MAX) ? COUNT_MAX : BUF_DEPTH;

    // configuration register map
    localparam int PADDR_W = 3;
    localparam logic REG_BUFFER_LIMIT = 1'b0;
    localparam logic REG_MIN_LENGTH   = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_STORED   = 3'd1,
        ST_DONE     = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // configuration seen by the decode stage
    typedef struct packed {
        logic [COUNT_W-1:0] limit;
        logic [7:0]         min_length;
    } cfg_t;

endpackage

FILE: src/slip_cfg_regs.sv
// apb configuration registers for the slip byte decoder
module slip_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slip_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output slip_pkg::cfg_t                cfg
);
    import slip_pkg::*;

    logic [COUNT_W-1:0] buffer_limit_reg;
    logic [7:0]         min_length_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_limit_reg <= COUNT_W'(256);
            min_length_reg   <= 8'd2;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_BUFFER_LIMIT: buffer_limit_reg <= pwdata[COUNT_W-1:0];
                REG_MIN_LENGTH:   min_length_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_BUFFER_LIMIT: prdata = {{(32-COUNT_W){1'b0}}, buffer_limit_reg};
            REG_MIN_LENGTH:   prdata = {24'd0, min_length_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // limit in effect is clamped to the buffer depth
    always_comb
    begin
        cfg.min_length = min_length_reg;
        if (32'(buffer_limit_reg) > LIMIT_CAP)
            cfg.limit = COUNT_W'(LIMIT_CAP);
        else
            cfg.limit = buffer_limit_reg;
    end

endmodule

FILE: src/slip_decode_core.sv
// frame state and per-byte decode into the result register
module slip_decode_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slip_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic [7:0]                    in_byte,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [7:0]                    data_byte,
    output logic [7:0]                    byte_index,
    output logic [slip_pkg::COUNT_W-1:0]  frame_length
);
    import slip_pkg::*;

    logic               escape_pending_reg, escape_pending_next;
    logic               overflow_error_reg, overflow_error_next;
    logic [COUNT_W-1:0] stored_count_reg, stored_count_next;

    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [7:0]         data_byte_reg, data_byte_next;
    logic [7:0]         byte_index_reg, byte_index_next;
    logic [COUNT_W-1:0] frame_length_reg, frame_length_next;

    logic               advance;
    logic               is_end;
    logic [7:0]         decoded;

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;
    assign is_end   = (in_byte == SYM_END);

    // escaped byte translation
    always_comb
    begin
        decoded = in_byte;
        if (escape_pending_reg)
        begin
            if (in_byte == SYM_ESC_END)
                decoded = SYM_END;
            else if (in_byte == SYM_ESC_ESC)
                decoded = SYM_ESC;
        end
    end

    // next state and result for one byte
    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        overflow_error_next = overflow_error_reg;
        stored_count_next   = stored_count_reg;
        status_next         = ST_NONE;
        data_byte_next      = 8'd0;
        byte_index_next     = 8'd0;
        frame_length_next   = '0;
        if (is_end)
        begin
            if (!overflow_error_reg && (stored_count_reg > COUNT_W'(cfg.min_length)))
            begin
                status_next       = ST_DONE;
                frame_length_next = stored_count_reg;
            end
            else if (overflow_error_reg || (stored_count_reg != '0))
            begin
                status_next = ST_DROPPED;
            end
            escape_pending_next = 1'b0;
            overflow_error_next = 1'b0;
            stored_count_next   = '0;
        end
        else if (in_byte == SYM_ESC && !escape_pending_reg)
        begin
            escape_pending_next = 1'b1;
        end
        else
        begin
            escape_pending_next = 1'b0;
            if (!overflow_error_reg)
            begin
                if (stored_count_reg < cfg.limit)
                begin
                    status_next       = ST_STORED;
                    data_byte_next    = decoded;
                    byte_index_next   = stored_count_reg[7:0];
                    stored_count_next = stored_count_reg + COUNT_W'(1);
                end
                else
                begin
                    overflow_error_next = 1'b1;
                    status_next         = ST_OVERFLOW;
                end
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            overflow_error_reg <= 1'b0;
            stored_count_reg   <= '0;
        end
        else if (advance)
        begin
            escape_pending_reg <= escape_pending_next;
            overflow_error_reg <= overflow_error_next;
            stored_count_reg   <= stored_count_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg       <= status_next;
            data_byte_reg    <= data_byte_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign data_byte    = data_byte_reg;
    assign byte_index   = byte_index_reg;
    assign frame_length = frame_length_reg;

`ifndef NO_ASSERTIONS
    // end of frame always restarts the frame state
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> !escape_pending_reg && !overflow_error_reg
                              && stored_count_reg == '0)
        else $error("frame state not cleared after end symbol");

    // overflow sticks until the end symbol
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && overflow_error_reg && !is_end |=> overflow_error_reg)
        else $error("overflow flag cleared inside a frame");

    // only a stored byte carries data and index
    a_stored_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_STORED |->
            data_byte_reg == 8'd0 && byte_index_reg == 8'd0)
        else $error("payload present on a result without a stored byte");

    // only a completed frame carries a length
    a_done_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_DONE |-> frame_length_reg == '0)
        else $error("frame length present on a result without completion");

    // a stalled result is never overwritten
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(status_reg)
                                        && $stable(data_byte_reg))
        else $error("stalled result changed");
`endif

endmodule

FILE: src/slip_byte_decoder.sv
// top level of the slip byte decoder
//
// Undoes slip byte stuffing on a stream of raw line bytes. Each raw byte
// beat on the input channel (in_valid/in_ready, raw_byte) yields exactly one
// result beat on the output channel (out_valid/out_ready): status, plus the
// decoded data_byte and its byte_index for a stored byte, or frame_length
// for a completed frame.
// From input acceptance to a valid result, the byte waits in the input
// register while the decode logic works on it, and the result register
// then loads the result. Throughput is one byte per cycle when the receiver
// does not stall; the decode stage is a single pass over the byte and the
// escape, overflow and count state. When the receiver stalls, the result
// register holds, the input register fills, and in_ready drops once both
// hold a beat; nothing is lost. Reset clears both registers' valid bits
// and the frame state; buffer_limit returns to 256 and min_length to 2.
// Configuration is written over the apb port at byte addresses 0
// (buffer_limit) and 4 (min_length); the user must write it only while the
// decoder is idle, as the block itself does not enforce this.
module slip_byte_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slip_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    raw_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [7:0]                    data_byte,
    output logic [7:0]                    byte_index,
    output logic [slip_pkg::COUNT_W-1:0]  frame_length
);
    import slip_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] raw_byte_reg;
    logic       core_ready;

    slip_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    assign in_ready = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            raw_byte_reg <= raw_byte;
    end

    slip_decode_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid_reg),
        .in_byte      (raw_byte_reg),
        .in_ready     (core_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length)
    );

endmodule

FILE: verif/slip_decode_checker.sv
// result checker for the slip byte decoder: tracks config, predicts each beat, compares
`timescale 1ns / 100ps

module slip_decode_checker
    import slip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         raw_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         byte_index,
    input  logic [COUNT_W-1:0] frame_length,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        status_t            status;
        logic [7:0]         data;
        logic [7:0]         index;
        logic [COUNT_W-1:0] length;
    } slip_result_t;

    // shadow copy of the registers and the frame state
    logic [COUNT_W-1:0] cfg_limit;
    logic [7:0]         cfg_min;
    logic               esc_pending;
    logic               ovf_error;
    logic [COUNT_W-1:0] byte_count;

    slip_result_t pending_results[$];
    slip_result_t want;
    int           mismatches;

    // one raw byte through the unstuffing rules
    function automatic slip_result_t unstuff_byte(input logic [7:0] b);
        slip_result_t       r;
        logic [7:0]         c;
        logic [COUNT_W-1:0] lim;
        r = '0;
        r.status = ST_NONE;
        lim = (int'(cfg_limit) > BUF_DEPTH) ? COUNT_W'(BUF_DEPTH) : cfg_limit;
        if (b == SYM_END) begin
            if (!ovf_error && byte_count > COUNT_W'(cfg_min)) begin
                r.status = ST_DONE;
                r.length = byte_count;
            end else if (ovf_error || byte_count != '0) begin
                r.status = ST_DROPPED;
            end
            esc_pending = 1'b0;
            ovf_error   = 1'b0;
            byte_count  = '0;
        end else if (b == SYM_ESC && !esc_pending) begin
            esc_pending = 1'b1;
        end else begin
            c = b;
            if (esc_pending) begin
                esc_pending = 1'b0;
                if (b == SYM_ESC_END)
                    c = SYM_END;
                else if (b == SYM_ESC_ESC)
                    c = SYM_ESC;
            end
            if (!ovf_error) begin
                if (byte_count < lim) begin
                    r.status = ST_STORED;
                    r.data   = c;
                    r.index  = byte_count[7:0];
                    byte_count = byte_count + 1'b1;
                end else begin
                    ovf_error = 1'b1;
                    r.status  = ST_OVERFLOW;
                end
            end
        end
        return r;
    endfunction

    // watch config writes, input beats and result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_limit   = COUNT_W'(256);
            cfg_min     = 8'd2;
            esc_pending = 1'b0;
            ovf_error   = 1'b0;
            byte_count  = '0;
            mismatches  = 0;
            pending_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_BUFFER_LIMIT)
                    cfg_limit = pwdata[COUNT_W-1:0];
                else if (paddr[PADDR_W-1:2] == REG_MIN_LENGTH)
                    cfg_min = pwdata[7:0];
            end

            if (in_valid && in_ready)
                pending_results.push_back(unstuff_byte(raw_byte));

            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("%0t: unexpected result beat: ", $realtime);
                        $display("status %0d data %h index %0d len %0d",
                                 status, data_byte, byte_index, frame_length);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || data_byte !== want.data ||
                        byte_index !== want.index || frame_length !== want.length)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t: result mismatch: expected status %0d data %h ",
                                   $realtime, want.status, want.data);
                            $write("index %0d len %0d, ", want.index, want.length);
                            $display("got status %0d data %h index %0d len %0d",
                                     status, data_byte, byte_index, frame_length);
                        end
                    end
                end
            end

            fail_count <= mismatches;
            pending    <= pending_results.size();
        end
    end

endmodule

FILE: verif/tb_slip_byte_decoder.sv
// testbench top for the slip byte decoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_slip_byte_decoder;
    import slip_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int NUM_PHASES  = 9;

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         raw_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic [7:0]         data_byte;
    logic [7:0]         byte_index;
    logic [COUNT_W-1:0] frame_length;

    int fail_count;
    int pending;

    bit gap_on   = 1'b0;
    bit stall_on = 1'b0;
    int items_sent = 0;
    int eff_limit  = 256;

    // per-phase settings; two entries are drawn at random at run time
    int phase_limit [NUM_PHASES] = '{256, 1, 0, 511, 256, 3, 0, 0, 256};
    int phase_min   [NUM_PHASES] = '{2, 0, 0, 0, 255, 1, 0, 0, 2};
    int phase_items [NUM_PHASES] = '{170, 120, 80, 170, 300, 120, 160, 160, 150};

    logic [7:0] opening_bytes[$] = '{
        SYM_END, 8'h00, 8'hFF, SYM_ESC, SYM_ESC_END, SYM_ESC, SYM_ESC_ESC,
        SYM_ESC, SYM_ESC, SYM_ESC, 8'h41, SYM_END, 8'h01, SYM_END,
        SYM_ESC, SYM_END, SYM_ESC_END, SYM_ESC_ESC, 8'hAA, 8'h55, SYM_END};
    logic [7:0] overflow_bytes[$] = '{
        8'h10, 8'h20, 8'h30, SYM_END, 8'h40, SYM_END};

    slip_byte_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_byte     (raw_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length)
    );

    slip_decode_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_byte     (raw_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // register write: setup cycle, then access until pready
    task automatic apb_write(input logic reg_idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one raw byte beat, with an occasional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (gap_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == SYM_END || b == SYM_ESC)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // mostly short frames, some medium, a few around the limit
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return $urandom_range(0, 10);
        else if (r < 17)
            return $urandom_range(0, 40);
        else
            return $urandom_range((eff_limit > 3) ? eff_limit - 3 : 0, eff_limit + 3);
    endfunction

    // payload with escapes and a little line noise (plain bytes only when clean), closed by END
    task automatic send_frame(input int len, input bit clean);
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = clean ? 19 : $urandom_range(0, 19);
            if (r < 3)
            begin
                send_byte(SYM_ESC);
                case ($urandom_range(0, 3))
                    0: send_byte(SYM_ESC_END);
                    1: send_byte(SYM_ESC_ESC);
                    2: send_byte(SYM_ESC);
                    default: send_byte(plain_byte());
                endcase
            end
            else if (r == 3)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(plain_byte());
        end
        send_byte(SYM_END);
    endtask

    // receiver: ready with random stall bursts
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat and no register access
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int  start;
        bit  paused;
        phase_limit[6] = $urandom_range(0, 511);
        phase_min[6]   = $urandom_range(0, 255);
        phase_limit[7] = $urandom_range(0, 20);
        phase_min[7]   = $urandom_range(0, 10);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every escape form, empty and short frames
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        wait_for_results(4);

        // directed: overflow with a one-byte limit
        apb_write(REG_BUFFER_LIMIT, 1);
        apb_write(REG_MIN_LENGTH, 0);
        foreach (overflow_bytes[i])
            send_byte(overflow_bytes[i]);
        wait_for_results(4);

        // random frames under a series of settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            gap_on   = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stall_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            apb_write(REG_BUFFER_LIMIT, phase_limit[ph]);
            apb_write(REG_MIN_LENGTH, phase_min[ph]);
            eff_limit = (phase_limit[ph] > BUF_DEPTH) ? BUF_DEPTH : phase_limit[ph];
            start  = items_sent;
            paused = 1'b0;

            // a full frame when only the longest frame can complete
            if (phase_min[ph] == 255)
                send_frame(eff_limit, 1'b1);

            while (items_sent - start < phase_items[ph])
            begin
                if (!paused && items_sent - start >= phase_items[ph] / 2)
                begin
                    wait_for_results(0);
                    paused = 1'b1;
                end
                send_frame(pick_len(), 1'b0);
            end
            wait_for_results(4);
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/slip_pkg.sv
src/slip_cfg_regs.sv
src/slip_decode_core.sv
src/slip_byte_decoder.sv
verif/slip_decode_checker.sv
verif/tb_slip_byte_decoder.sv
